### rtl/kmc_pkg.sv
// Shared types, key codes and pitch tables for the key to MIDI chord mapper.
package kmc_pkg;

  localparam int NOTES_MAX = 4;

  localparam logic [4:0] KEY_DEG_FIRST   = 5'd10;
  localparam logic [4:0] KEY_OCT_DOWN    = 5'd15;
  localparam logic [4:0] KEY_OCT_UP      = 5'd16;
  localparam logic [4:0] KEY_SCALE_FIRST = 5'd17;
  localparam logic [4:0] KEY_QUAL_FIRST  = 5'd22;
  localparam logic [4:0] KEY_COUNT       = 5'd27;

  localparam logic signed [5:0] OCT_STEP = 6'sd12;
  localparam logic signed [5:0] OCT_MAX  = 6'sd24;
  localparam logic signed [5:0] OCT_MIN  = -6'sd24;

  localparam logic [6:0] VEL_ON  = 7'd127;
  localparam logic [6:0] VEL_OFF = 7'd0;

  localparam logic [2:0] SCALE_NONE = 3'd0;
  localparam logic [2:0] SCALE_MAX  = 3'd5;

  typedef logic [NOTES_MAX-1:0][6:0] note_vec_t;

  typedef struct packed {
    logic [NOTES_MAX-1:0] keep;
    note_vec_t            note;
  } run_t;

  function automatic logic [6:0] single_base(input logic [3:0] idx);
    logic [6:0] b;
    unique case (idx)
      4'd0: b = 7'd48;
      4'd1: b = 7'd50;
      4'd2: b = 7'd52;
      4'd3: b = 7'd53;
      4'd4: b = 7'd55;
      4'd5: b = 7'd57;
      4'd6: b = 7'd59;
      4'd7: b = 7'd60;
      4'd8: b = 7'd62;
      4'd9: b = 7'd64;
      default: b = 7'd48;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] degree_root(input logic [2:0] idx);
    logic [6:0] b;
    unique case (idx)
      3'd0: b = 7'd48;
      3'd1: b = 7'd53;
      3'd2: b = 7'd55;
      3'd3: b = 7'd57;
      3'd4: b = 7'd50;
      default: b = 7'd48;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] interval(input logic [2:0] kind, input logic [1:0] slot);
    logic [3:0] v;
    unique case (slot)
      2'd0: v = 4'd0;
      2'd1: v = (kind == 3'd1) ? 4'd3 : ((kind == 3'd3) ? 4'd5 : 4'd4);
      2'd2: v = 4'd7;
      2'd3: v = (kind == 3'd2) ? 4'd10 : 4'd14;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic has_fourth(input logic [2:0] kind);
    return (kind == 3'd2) || (kind == 3'd4);
  endfunction

  function automatic logic [11:0] scale_mask(input logic [2:0] sel);
    logic [11:0] m;
    unique case (sel)
      3'd1: m = 12'h AB5;
      3'd2: m = 12'h 5AF;
      3'd3: m = 12'h 529;
      3'd4: m = 12'h C69;
      3'd5: m = 12'h FFF;
      default: m = 12'h FFF;
    endcase
    return m;
  endfunction

  // n mod 12 for n < 128: quotient by reciprocal 43/512
  function automatic logic [3:0] mod12(input logic [6:0] n);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 13'(n) * 13'd43;
    q    = prod[12:9];
    r    = n - 7'(q) * 7'd12;
    return r[3:0];
  endfunction

endpackage

### rtl/kmc_if.sv
// Valid/ready channel interfaces for key events and MIDI note results.
interface kmc_key_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [4:0] key_index;
  logic       pressed;

  modport source (output valid, key_index, pressed, input ready);
  modport sink   (input valid, key_index, pressed, output ready);
endinterface

interface kmc_note_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [6:0] note;
  logic [6:0] velocity;
  logic       last;

  modport source (output valid, note, velocity, last, input ready);
  modport sink   (input valid, note, velocity, last, output ready);
endinterface

### rtl/key_to_midi_chord_mapper_unit.sv
// Top level: key events in, MIDI note-on results out, one note per ready cycle.
//
//   channel | modport | payload                  | role
//   key     | sink    | key_index, pressed       | key press or release events
//   midi    | source  | note, velocity, last     | note-on messages, last ends a run
//
// An event is decoded in the cycle it transfers; its 0 to 4 notes sit in a run
// register and leave one per cycle from the next cycle on while midi is ready.
// A new event transfers once the run is empty or its last note is leaving.
// Setting keys produce no notes and transfer back to back.
// Synchronous reset clears settings and the run; midi stalls just hold the run.
module key_to_midi_chord_mapper_unit (
  input logic        clk,
  input logic        rst,
  kmc_key_if.sink    key,
  kmc_note_if.source midi
);
  import kmc_pkg::*;

  logic signed [5:0]    octave_shift;
  logic [2:0]           scale_select;
  logic [2:0]           chord_kind;
  logic [NOTES_MAX-1:0] keep;
  note_vec_t            notes;
  logic [6:0]           vel;

  run_t                 gen_run;
  logic [NOTES_MAX-1:0] pick;
  logic [NOTES_MAX-1:0] rest;
  logic                 in_xfer;
  logic                 out_xfer;

  kmc_note_gen u_gen (
    .key_index    (key.key_index),
    .octave_shift (octave_shift),
    .scale_select (scale_select),
    .chord_kind   (chord_kind),
    .run          (gen_run)
  );

  assign pick = keep & (~keep + NOTES_MAX'(1));
  assign rest = keep & ~pick;

  always_comb begin
    midi.note = notes[0];
    for (int i = NOTES_MAX - 1; i >= 0; i--) begin
      if (pick[i]) begin
        midi.note = notes[i];
      end
    end
  end

  assign midi.valid    = |keep;
  assign midi.velocity = vel;
  assign midi.last     = (rest == '0);
  assign out_xfer      = midi.valid && midi.ready;
  assign key.ready     = (keep == '0) || (out_xfer && midi.last);
  assign in_xfer       = key.valid && key.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_shift <= '0;
      scale_select <= SCALE_NONE;
      chord_kind   <= '0;
      keep         <= '0;
    end else begin
      if (in_xfer) begin
        keep <= gen_run.keep;
      end else if (out_xfer) begin
        keep <= rest;
      end
      if (in_xfer && key.pressed) begin
        if (key.key_index == KEY_OCT_DOWN) begin
          if (octave_shift > OCT_MIN) octave_shift <= octave_shift - OCT_STEP;
        end else if (key.key_index == KEY_OCT_UP) begin
          if (octave_shift < OCT_MAX) octave_shift <= octave_shift + OCT_STEP;
        end else if (key.key_index >= KEY_SCALE_FIRST && key.key_index < KEY_QUAL_FIRST) begin
          scale_select <= 3'(key.key_index - KEY_SCALE_FIRST) + 3'd1;
        end else if (key.key_index >= KEY_QUAL_FIRST && key.key_index < KEY_COUNT) begin
          chord_kind <= 3'(key.key_index - KEY_QUAL_FIRST);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      notes <= gen_run.note;
      vel   <= key.pressed ? VEL_ON : VEL_OFF;
    end
  end

endmodule

### rtl/kmc_note_gen.sv
// Note set of one key event: pitches after octave offset, filtered by scale.
module kmc_note_gen (
  input  logic [4:0]        key_index,
  input  logic signed [5:0] octave_shift,
  input  logic [2:0]        scale_select,
  input  logic [2:0]        chord_kind,
  output kmc_pkg::run_t     run
);
  import kmc_pkg::*;

  logic [NOTES_MAX-1:0] used;
  note_vec_t            base;
  logic [2:0]           kind;
  logic [2:0]           deg;
  logic [11:0]          mask;
  logic                 filt;
  logic [4:0]           deg_off;

  assign kind    = (chord_kind < 3'd5) ? chord_kind : 3'd0;
  assign deg_off = key_index - KEY_DEG_FIRST;
  assign deg     = deg_off[2:0];
  assign mask    = scale_mask(scale_select);
  assign filt    = (scale_select != SCALE_NONE) && (scale_select <= SCALE_MAX);

  always_comb begin
    used = '0;
    base = '0;
    if (key_index < KEY_DEG_FIRST) begin
      used[0] = 1'b1;
      base[0] = single_base(key_index[3:0]);
    end else if (key_index < KEY_OCT_DOWN) begin
      for (int i = 0; i < NOTES_MAX; i++) begin
        base[i] = degree_root(deg) + 7'(interval(kind, 2'(i)));
      end
      used = {has_fourth(kind), 3'b111};
    end
  end

  always_comb begin
    logic signed [7:0] sum;
    for (int i = 0; i < NOTES_MAX; i++) begin
      sum = $signed({1'b0, base[i]}) + 8'(octave_shift);
      run.note[i] = sum[6:0];
      run.keep[i] = used[i] && (!filt || mask[mod12(sum[6:0])]);
    end
  end

endmodule

### rtl/kmc_checker.sv
// Port-level assertions for the mapper, bound to the top level.
module kmc_checker (
  input logic       clk,
  input logic       rst,
  input logic       key_ready,
  input logic       midi_valid,
  input logic       midi_ready,
  input logic [6:0] note,
  input logic [6:0] velocity,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    midi_valid && !midi_ready |=> midi_valid && $stable(note) && $stable(velocity)
      && $stable(last))
    else $error("stalled note changed");

  a_vel: assert property (@(posedge clk) disable iff (rst)
    midi_valid |-> (velocity == 7'd0 || velocity == 7'd127))
    else $error("bad velocity");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    !key_ready |-> midi_valid)
    else $error("key stalled with no pending note");

  a_run: assert property (@(posedge clk) disable iff (rst)
    midi_valid && midi_ready && !last |=> midi_valid && velocity == $past(velocity))
    else $error("run broken");

  a_range: assert property (@(posedge clk) disable iff (rst)
    midi_valid |-> note >= 7'd24 && note <= 7'd102)
    else $error("note out of range");

endmodule

bind key_to_midi_chord_mapper_unit kmc_checker u_kmc_checker (
  .clk        (clk),
  .rst        (rst),
  .key_ready  (key.ready),
  .midi_valid (midi.valid),
  .midi_ready (midi.ready),
  .note       (midi.note),
  .velocity   (midi.velocity),
  .last       (midi.last)
);
